[hw/rtl/rbps_pkg.sv]
`timescale 1ns / 1ps
package rbps_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] CFG_MAX_VALUE   = 8'd0;
  localparam logic [7:0] CFG_SOURCE_31   = 8'd1;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEFT_W   = 15;
  localparam int unsigned ACC_W    = WORD_W + LEFT_W;

  localparam logic [15:0] MAX_VALUE_RESET = 16'hffff;

  // Status of the serial remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  // Number of significant bits of a 16-bit value
  function automatic logic [4:0] bit_length(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

endpackage

[hw/rtl/rbps_serial_mod.sv]
`timescale 1ns / 1ps
module rbps_serial_mod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          dividend,
  input  logic [16:0]          modulus,
  output rbps_pkg::mod_stat_t  stat,
  output logic [15:0]          remainder
);
  import rbps_pkg::*;

  logic [31:0] bits;
  logic [15:0] rem;
  logic [16:0] m;
  logic [4:0]  cnt;
  logic        running;
  logic        have;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem, bits[31]};
  assign diff  = trial - m;
  assign fits  = trial >= m;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      have    <= 1'b0;
      cnt     <= 5'd0;
    end else if (start) begin
      running <= 1'b1;
      have    <= 1'b0;
      cnt     <= 5'd0;
    end else if (running) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        running <= 1'b0;
        have    <= 1'b1;
      end
    end
  end

  // Hold operands and advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      bits <= dividend;
      m    <= modulus;
      rem  <= 16'd0;
    end else if (running) begin
      bits <= {bits[30:0], 1'b0};
      rem  <= fits ? diff[15:0] : trial[15:0];
    end
  end

  assign stat.busy = running;
  assign stat.done = have & ~running;
  assign remainder = rem;

endmodule

[hw/rtl/random_bit_pool_sampler.sv]
`timescale 1ns / 1ps
// Random bit pool sampler. Each accepted 32-bit word (31 valid bits when
// source_is_31_bit is set) becomes noise samples in 0..max_value. With
// max_value = 2^n-1 the word's bits are appended above the pool left over
// from earlier words and every whole n-bit chunk is issued, lowest first, one
// sample per cycle while the output is not stalled, through a single variable
// shifter: floor((leftover + valid bits) / n) samples per item, after a load
// step. Any other max_value yields one sample, word mod (max_value+1), from a
// one-bit-per-cycle restoring remainder unit. The final sample of each word
// carries last_of_word. Input stall is high from acceptance until the last
// sample is in the output register; the output register lets the next item
// in while that sample still waits. Writing max_value empties the pool. The
// configuration port is always ready and is meant to be written only while
// the block is idle.
module random_bit_pool_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] sample,
  output logic        last_of_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rbps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POOL = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  logic [1:0]        state;
  logic [15:0]       max_value;
  logic              source_is_31_bit;
  logic [LEFT_W-1:0] leftover_bits;
  logic [3:0]        leftover_count;
  logic [ACC_W-1:0]  acc;
  logic [5:0]        total;
  logic [4:0]        n_reg;

  logic              in_acc;
  logic              slot_free;
  logic [31:0]       word_m;
  logic              pool_mode;
  logic [16:0]       max_ext;
  logic [ACC_W-1:0]  acc_shift;
  logic [5:0]        total_next;
  logic              chunk_last;
  logic              cfg_wr;
  mod_stat_t         mstat;
  logic [15:0]       mrem;
  logic              mstart;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign slot_free = ~out_valid | ~out_stall;

  // Mask the top bit for a 31-bit source; decide the mode
  assign word_m    = source_is_31_bit ? {1'b0, random_word[30:0]} : random_word;
  assign max_ext   = {1'b0, max_value};
  assign pool_mode = (max_value != 16'd0) && ((max_ext & (max_ext + 17'd1)) == 17'd0);
  assign mstart    = in_acc & ~pool_mode;

  // Shared shifter: drop one chunk per sample
  assign acc_shift  = acc >> n_reg;
  assign total_next = total - {1'b0, n_reg};
  assign chunk_last = total < {n_reg, 1'b0};

  rbps_serial_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mstart),
    .dividend  (word_m),
    .modulus   (max_ext + 17'd1),
    .stat      (mstat),
    .remainder (mrem)
  );

  // Sequencer, configuration and pool state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      max_value        <= MAX_VALUE_RESET;
      source_is_31_bit <= 1'b0;
      leftover_bits    <= '0;
      leftover_count   <= 4'd0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_MAX_VALUE: begin
            max_value      <= cfg_data;
            leftover_bits  <= '0;
            leftover_count <= 4'd0;
          end
          CFG_SOURCE_31: source_is_31_bit <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) state <= pool_mode ? ST_POOL : ST_MOD;
        end
        ST_POOL: begin
          if (slot_free && chunk_last) begin
            state          <= ST_IDLE;
            leftover_bits  <= acc_shift[LEFT_W-1:0];
            leftover_count <= total_next[3:0];
          end
        end
        ST_MOD: begin
          if (slot_free && mstat.done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Load the pool accumulator, then advance it one chunk per sample
  always_ff @(posedge clk) begin
    if (in_acc && pool_mode) begin
      acc   <= ({{LEFT_W{1'b0}}, word_m} << leftover_count) |
               {{WORD_W{1'b0}}, leftover_bits};
      total <= {2'b00, leftover_count} + (source_is_31_bit ? 6'd31 : 6'd32);
      n_reg <= bit_length(max_value);
    end else if (state == ST_POOL && slot_free) begin
      acc   <= acc_shift;
      total <= total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_POOL && slot_free) ||
                 (state == ST_MOD && slot_free && mstat.done)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POOL && slot_free) begin
      sample       <= acc[SAMPLE_W-1:0] & max_value;
      last_of_word <= chunk_last;
    end else if (state == ST_MOD && slot_free && mstat.done) begin
      sample       <= mrem;
      last_of_word <= 1'b1;
    end
  end

  // Checks
  a_pool_enough_bits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POOL) |-> (total >= {1'b0, n_reg}))
    else $error("pool ran short of bits");

  a_leftover_below_chunk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && pool_mode) |-> ({1'b0, leftover_count} < bit_length(max_value)))
    else $error("leftover pool not smaller than one chunk");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("accepted item did not start work");

  a_mod_busy_in_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> (mstat.busy || mstat.done))
    else $error("remainder unit idle while waited on");

endmodule
